### rtl/pps_pkg.sv
// Shared constants, codes, types and helper functions for the photoperiod phase sequencer.
`default_nettype none

package pps_pkg;

    // Field widths.
    localparam int CNT_W   = 17;
    localparam int HOURS_W = 5;
    localparam int DIV_W   = 16;
    localparam int MIN_W   = 6;
    localparam int FRAC_W  = 12;
    localparam int CFG_A_W = 3;
    localparam int CFG_D_W = 17;
    localparam int STEP_W  = 5;

    // Time constants.
    localparam logic [CNT_W-1:0]   CNT_MAX       = 17'h1FFFF;
    localparam logic [CNT_W-1:0]   SEC_PER_HOUR  = 17'd3600;
    localparam logic [FRAC_W-1:0]  FRAC_LAST     = 12'd3599;
    localparam logic [MIN_W-1:0]   SEC_PER_MIN   = 6'd60;
    localparam logic [MIN_W-1:0]   MIN_PER_HOUR  = 6'd60;
    localparam logic [HOURS_W-1:0] HOURS_PER_DAY = 5'd24;

    // Number of bit steps in one serial remainder pass.
    localparam logic [STEP_W-1:0]  MOD_STEPS     = 5'd17;

    // Phase codes.
    localparam logic [1:0] PHASE_DAY      = 2'd0;
    localparam logic [1:0] PHASE_TO_NIGHT = 2'd1;
    localparam logic [1:0] PHASE_NIGHT    = 2'd2;
    localparam logic [1:0] PHASE_TO_DAY   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_A_W-1:0] CFG_DAY_HOURS        = 3'd0;
    localparam logic [CFG_A_W-1:0] CFG_NIGHT_HOURS      = 3'd1;
    localparam logic [CFG_A_W-1:0] CFG_TRANSITION_HOURS = 3'd2;
    localparam logic [CFG_A_W-1:0] CFG_DIMMING_INTERVAL = 3'd3;
    localparam logic [CFG_A_W-1:0] CFG_LOG_PERIOD       = 3'd4;

    // Configuration reset values.
    localparam logic [HOURS_W-1:0] DAY_HOURS_RST   = 5'd12;
    localparam logic [HOURS_W-1:0] NIGHT_HOURS_RST = 5'd10;
    localparam logic [HOURS_W-1:0] TRANS_HOURS_RST = 5'd1;
    localparam logic [DIV_W-1:0]   DIM_INTVL_RST   = 16'd60;
    localparam logic [CNT_W-1:0]   LOG_PERIOD_RST  = 17'd900;

    // Status of the serial remainder unit.
    typedef struct packed {
        logic busy;
        logic zero;
    } pps_mod_status_t;

    // Length in hours of a given phase.
    function automatic logic [HOURS_W-1:0] phase_hours(
        input logic [1:0]         ph,
        input logic [HOURS_W-1:0] day_h,
        input logic [HOURS_W-1:0] night_h,
        input logic [HOURS_W-1:0] trans_h
    );
        logic [HOURS_W-1:0] h;
        begin
            case (ph)
                PHASE_DAY:   h = day_h;
                PHASE_NIGHT: h = night_h;
                default:     h = trans_h;
            endcase
            return h;
        end
    endfunction

    // Hours to seconds; at most 31 hours, which fits in 17 bits.
    function automatic logic [CNT_W-1:0] hours_to_sec(input logic [HOURS_W-1:0] h);
        logic [CNT_W-1:0] s;
        begin
            s = CNT_W'(h) * SEC_PER_HOUR;
            return s;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/pps_serial_mod.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`default_nettype none

module pps_serial_mod (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [pps_pkg::CNT_W-1:0]    dividend,
    input  wire logic [pps_pkg::DIV_W-1:0]    divisor,
    output pps_pkg::pps_mod_status_t          status
);
    import pps_pkg::*;

    logic [CNT_W-1:0]  dvd_reg;
    logic [DIV_W-1:0]  dsr_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;

    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;
    logic [DIV_W-1:0]  rem_next;

    // The partial remainder stays below the divisor, so the trial value fits in 17 bits.
    always_comb
    begin
        trial = {rem_reg, dvd_reg[CNT_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        if (trial >= {1'b0, dsr_reg})
        begin
            rem_next = diff[DIV_W-1:0];
        end
        else
        begin
            rem_next = trial[DIV_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= MOD_STEPS;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[CNT_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.zero = (rem_reg == '0);

endmodule

`default_nettype wire

### rtl/photoperiod_phase_sequencer.sv
// Top level of the photoperiod phase sequencer: phase timing, time of day and log pulses.
// Flow: a plain poll, or a tick that lands outside a transition phase or meets a zero dimming
// interval, goes from idle straight to the done state; any other tick first runs the 17-step
// bit-serial remainder against the dimming interval. The done state waits for a free output.
// One request is in flight at a time; the result register lets the next one be taken while the
// last result waits. Reset clears all timing state (day phase) and loads register defaults.
`default_nettype none

module photoperiod_phase_sequencer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Configuration write port.
    input  wire logic                          cfg_we,
    input  wire logic [pps_pkg::CFG_A_W-1:0]   cfg_addr,
    input  wire logic [pps_pkg::CFG_D_W-1:0]   cfg_wdata,
    // Request channel.
    input  wire logic                          in_valid,
    output      logic                          in_ready,
    input  wire logic                          second_tick,
    // Result channel.
    output      logic                          out_valid,
    input  wire logic                          out_ready,
    output      logic [1:0]                    phase,
    output      logic [pps_pkg::CNT_W-1:0]     phase_seconds,
    output      logic [pps_pkg::HOURS_W-1:0]   hours_left,
    output      logic [pps_pkg::HOURS_W-1:0]   clock_hour,
    output      logic [pps_pkg::MIN_W-1:0]     clock_minute,
    output      logic [pps_pkg::MIN_W-1:0]     clock_second,
    output      logic                          dimming_step,
    output      logic                          refresh_dimming,
    output      logic                          phase_changed,
    output      logic                          log_request
);
    import pps_pkg::*;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MOD  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Configuration registers.
    logic [HOURS_W-1:0] day_hours_reg;
    logic [HOURS_W-1:0] night_hours_reg;
    logic [HOURS_W-1:0] trans_hours_reg;
    logic [DIV_W-1:0]   dim_intvl_reg;
    logic [CNT_W-1:0]   log_period_reg;

    // Timing state. The hour fraction tracks the phase counter modulo 3600, so the whole-hour
    // check needs no divider.
    logic [1:0]         phase_reg;
    logic [CNT_W-1:0]   phase_cnt_reg;
    logic [FRAC_W-1:0]  hour_frac_reg;
    logic [HOURS_W-1:0] hours_left_reg;
    logic [CNT_W-1:0]   log_cnt_reg;
    logic [HOURS_W-1:0] tod_h_reg;
    logic [MIN_W-1:0]   tod_m_reg;
    logic [MIN_W-1:0]   tod_s_reg;

    // Pulses of the request in flight.
    logic               dim_p_reg;
    logic               refresh_p_reg;
    logic               changed_p_reg;
    logic               logreq_p_reg;

    // Result register.
    logic               out_valid_reg;
    logic [1:0]         phase_o_reg;
    logic [CNT_W-1:0]   phase_sec_o_reg;
    logic [HOURS_W-1:0] hours_left_o_reg;
    logic [HOURS_W-1:0] clock_h_o_reg;
    logic [MIN_W-1:0]   clock_m_o_reg;
    logic [MIN_W-1:0]   clock_s_o_reg;
    logic               dim_o_reg;
    logic               refresh_o_reg;
    logic               changed_o_reg;
    logic               logreq_o_reg;

    // Next values for a tick.
    logic               accept;
    logic               tick_go;
    logic [CNT_W-1:0]   cnt_inc;
    logic [FRAC_W-1:0]  frac_inc;
    logic               phase_end;
    logic [1:0]         phase_adv;
    logic [1:0]         phase_next;
    logic [CNT_W-1:0]   phase_cnt_next;
    logic [FRAC_W-1:0]  hour_frac_next;
    logic [HOURS_W-1:0] hours_left_next;
    logic [MIN_W-1:0]   tod_s_next;
    logic [MIN_W-1:0]   tod_m_next;
    logic [HOURS_W-1:0] tod_h_next;
    logic [MIN_W-1:0]   s_inc;
    logic [MIN_W-1:0]   m_inc;
    logic [HOURS_W-1:0] h_inc;
    logic               m_carry;
    logic               h_carry;
    logic [CNT_W-1:0]   log_inc;
    logic               log_fire;
    logic [CNT_W-1:0]   log_cnt_next;
    logic               need_mod;
    logic               out_load;

    pps_mod_status_t    mod_status;

    assign accept   = in_valid && in_ready;
    assign tick_go  = accept && second_tick;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // Phase counter advance and phase change. The counter saturates, and the hour fraction
    // holds with it.
    always_comb
    begin
        if (phase_cnt_reg != CNT_MAX)
        begin
            cnt_inc  = phase_cnt_reg + CNT_W'(1);
            frac_inc = (hour_frac_reg == FRAC_LAST) ? '0 : hour_frac_reg + FRAC_W'(1);
        end
        else
        begin
            cnt_inc  = phase_cnt_reg;
            frac_inc = hour_frac_reg;
        end

        phase_end = (cnt_inc >= hours_to_sec(phase_hours(phase_reg, day_hours_reg,
                                                         night_hours_reg, trans_hours_reg)));
        phase_adv = phase_reg + 2'd1;

        if (phase_end)
        begin
            phase_next      = phase_adv;
            phase_cnt_next  = '0;
            hour_frac_next  = '0;
            hours_left_next = phase_hours(phase_adv, day_hours_reg, night_hours_reg,
                                          trans_hours_reg);
        end
        else
        begin
            phase_next      = phase_reg;
            phase_cnt_next  = cnt_inc;
            hour_frac_next  = frac_inc;
            // Count down one at every whole hour of the phase, never below zero.
            if ((cnt_inc != '0) && (frac_inc == '0) && (hours_left_reg != '0))
            begin
                hours_left_next = hours_left_reg - HOURS_W'(1);
            end
            else
            begin
                hours_left_next = hours_left_reg;
            end
        end

        // The remainder pass is only needed in a transition phase with a nonzero interval.
        need_mod = phase_next[0] && (dim_intvl_reg != '0);
    end

    // Time of day, wrapping at 60 seconds, 60 minutes and 24 hours.
    always_comb
    begin
        s_inc   = tod_s_reg + MIN_W'(1);
        m_carry = (s_inc >= SEC_PER_MIN);
        tod_s_next = m_carry ? '0 : s_inc;

        m_inc   = m_carry ? tod_m_reg + MIN_W'(1) : tod_m_reg;
        h_carry = (m_inc >= MIN_PER_HOUR);
        tod_m_next = h_carry ? '0 : m_inc;

        h_inc   = h_carry ? tod_h_reg + HOURS_W'(1) : tod_h_reg;
        tod_h_next = (h_inc >= HOURS_PER_DAY) ? '0 : h_inc;
    end

    // Log period counter, saturating before the compare.
    always_comb
    begin
        log_inc  = (log_cnt_reg != CNT_MAX) ? log_cnt_reg + CNT_W'(1) : log_cnt_reg;
        log_fire = (log_inc >= log_period_reg);
        log_cnt_next = log_fire ? '0 : log_inc;
    end

    // Sequencer: take a request, run the remainder pass when needed, then hand the result
    // to the output register as soon as it is free.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (second_tick && need_mod) ? ST_MOD : ST_DONE;
                end
            end
            ST_MOD:
            begin
                if (!mod_status.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    pps_serial_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (tick_go && need_mod),
        .dividend (phase_cnt_next),
        .divisor  (dim_intvl_reg),
        .status   (mod_status)
    );

    // Control state, configuration, timing state, pulses of the request in flight and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            day_hours_reg   <= DAY_HOURS_RST;
            night_hours_reg <= NIGHT_HOURS_RST;
            trans_hours_reg <= TRANS_HOURS_RST;
            dim_intvl_reg   <= DIM_INTVL_RST;
            log_period_reg  <= LOG_PERIOD_RST;
            phase_reg       <= PHASE_DAY;
            phase_cnt_reg   <= '0;
            hour_frac_reg   <= '0;
            hours_left_reg  <= '0;
            log_cnt_reg     <= '0;
            tod_h_reg       <= '0;
            tod_m_reg       <= '0;
            tod_s_reg       <= '0;
            dim_p_reg       <= 1'b0;
            refresh_p_reg   <= 1'b0;
            changed_p_reg   <= 1'b0;
            logreq_p_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_DAY_HOURS:        day_hours_reg   <= cfg_wdata[HOURS_W-1:0];
                    CFG_NIGHT_HOURS:      night_hours_reg <= cfg_wdata[HOURS_W-1:0];
                    CFG_TRANSITION_HOURS: trans_hours_reg <= cfg_wdata[HOURS_W-1:0];
                    CFG_DIMMING_INTERVAL: dim_intvl_reg   <= cfg_wdata[DIV_W-1:0];
                    CFG_LOG_PERIOD:       log_period_reg  <= cfg_wdata[CNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (accept)
            begin
                // A plain poll leaves the state alone and raises no pulse.
                dim_p_reg     <= 1'b0;
                refresh_p_reg <= tick_go && phase_end && phase_reg[0];
                changed_p_reg <= tick_go && phase_end;
                logreq_p_reg  <= tick_go && log_fire;
            end
            else if ((state_reg == ST_MOD) && !mod_status.busy)
            begin
                dim_p_reg <= mod_status.zero;
            end

            if (tick_go)
            begin
                phase_reg      <= phase_next;
                phase_cnt_reg  <= phase_cnt_next;
                hour_frac_reg  <= hour_frac_next;
                hours_left_reg <= hours_left_next;
                tod_s_reg      <= tod_s_next;
                tod_m_reg      <= tod_m_next;
                tod_h_reg      <= tod_h_next;
                log_cnt_reg    <= log_cnt_next;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, captured from the updated state.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            phase_o_reg      <= phase_reg;
            phase_sec_o_reg  <= phase_cnt_reg;
            hours_left_o_reg <= hours_left_reg;
            clock_h_o_reg    <= tod_h_reg;
            clock_m_o_reg    <= tod_m_reg;
            clock_s_o_reg    <= tod_s_reg;
            dim_o_reg        <= dim_p_reg;
            refresh_o_reg    <= refresh_p_reg;
            changed_o_reg    <= changed_p_reg;
            logreq_o_reg     <= logreq_p_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign phase           = phase_o_reg;
    assign phase_seconds   = phase_sec_o_reg;
    assign hours_left      = hours_left_o_reg;
    assign clock_hour      = clock_h_o_reg;
    assign clock_minute    = clock_m_o_reg;
    assign clock_second    = clock_s_o_reg;
    assign dimming_step    = dim_o_reg;
    assign refresh_dimming = refresh_o_reg;
    assign phase_changed   = changed_o_reg;
    assign log_request     = logreq_o_reg;

endmodule

`default_nettype wire

### test/tb_photoperiod_phase_sequencer.sv
// Self-checking testbench for the photoperiod phase sequencer: directed table, then random runs.
`timescale 1ns / 1ps

module tb_photoperiod_phase_sequencer;

    import pps_pkg::*;

    // Cycles to wait once nothing is outstanding. This covers the slowest request, a tick
    // inside a transition phase, with margin.
    localparam int SETTLE_CYCLES = 32;

    // Hard stop for the whole run.
    localparam int LIMIT_CYCLES  = 2_000_000;

    // One result as the block reports it, fields in port order.
    typedef struct packed {
        logic [1:0]         phase;
        logic [CNT_W-1:0]   phase_seconds;
        logic [HOURS_W-1:0] hours_left;
        logic [HOURS_W-1:0] clock_hour;
        logic [MIN_W-1:0]   clock_minute;
        logic [MIN_W-1:0]   clock_second;
        logic               dimming_step;
        logic               refresh_dimming;
        logic               phase_changed;
        logic               log_request;
    } status_t;

    // A row of the directed table is either a register write or one request.
    typedef enum logic {
        ROW_WRITE,
        ROW_SEND
    } row_kind_e;

    typedef struct {
        row_kind_e          kind;
        logic [CFG_A_W-1:0] addr;
        logic [CFG_D_W-1:0] data;
        logic               tick;
        logic               typed;
        status_t            want;
    } stim_row_t;

    // Ways the result side holds off the block.
    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_QUARTER,
        SINK_RUNS
    } sink_mode_e;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic               cfg_we      = 1'b0;
    logic [CFG_A_W-1:0] cfg_addr    = '0;
    logic [CFG_D_W-1:0] cfg_wdata   = '0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic               second_tick = 1'b0;
    logic               out_valid;
    logic               out_ready   = 1'b0;

    logic [1:0]         phase;
    logic [CNT_W-1:0]   phase_seconds;
    logic [HOURS_W-1:0] hours_left;
    logic [HOURS_W-1:0] clock_hour;
    logic [MIN_W-1:0]   clock_minute;
    logic [MIN_W-1:0]   clock_second;
    logic               dimming_step;
    logic               refresh_dimming;
    logic               phase_changed;
    logic               log_request;

    // Our own copy of the configuration, kept at register widths.
    logic [HOURS_W-1:0] day_len;
    logic [HOURS_W-1:0] night_len;
    logic [HOURS_W-1:0] dusk_len;
    logic [DIV_W-1:0]   dim_every;
    logic [CNT_W-1:0]   log_every;

    // Our own copy of the timing state.
    logic [1:0]         sched_phase;
    logic [CNT_W-1:0]   sched_count;
    logic [HOURS_W-1:0] sched_hours;
    logic [CNT_W-1:0]   log_count;
    logic [HOURS_W-1:0] tod_h;
    logic [MIN_W-1:0]   tod_m;
    logic [MIN_W-1:0]   tod_s;

    // Results still owed by the block, oldest first.
    status_t status_due[$];

    int mismatches = 0;
    int cycles     = 0;

    sink_mode_e  sink_mode = SINK_OPEN;
    int unsigned sink_left = 0;
    int unsigned sink_beat = 0;

    photoperiod_phase_sequencer u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .second_tick     (second_tick),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .phase           (phase),
        .phase_seconds   (phase_seconds),
        .hours_left      (hours_left),
        .clock_hour      (clock_hour),
        .clock_minute    (clock_minute),
        .clock_second    (clock_second),
        .dimming_step    (dimming_step),
        .refresh_dimming (refresh_dimming),
        .phase_changed   (phase_changed),
        .log_request     (log_request)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Configured length in hours of the given phase.
    function automatic logic [HOURS_W-1:0] hours_in_phase(input logic [1:0] ph);
        case (ph)
            PHASE_DAY:   return day_len;
            PHASE_NIGHT: return night_len;
            default:     return dusk_len;
        endcase
    endfunction

    function automatic logic is_transition(input logic [1:0] ph);
        return (ph == PHASE_TO_NIGHT) || (ph == PHASE_TO_DAY);
    endfunction

    // Advances the schedule by one request and returns what the block should report.
    // A plain poll leaves every piece of state alone and raises no pulse.
    function automatic status_t advance_schedule(input logic tick);
        status_t     st;
        int unsigned span;
        st = '0;
        if (tick) begin
            if (sched_count < CNT_MAX)
                sched_count = sched_count + CNT_W'(1);

            // Phase end. The compare is >=, so a length of zero ends the phase on every
            // tick, and a length lowered below the running count ends it on the next one.
            span = 32'(hours_in_phase(sched_phase)) * 32'(SEC_PER_HOUR);
            if (32'(sched_count) >= span) begin
                st.refresh_dimming = is_transition(sched_phase);
                sched_count        = '0;
                sched_phase        = sched_phase + 2'd1;
                sched_hours        = hours_in_phase(sched_phase);
                st.phase_changed   = 1'b1;
            end

            // Dimming steps only in transitions; a freshly cleared count is a multiple.
            if (is_transition(sched_phase) && dim_every != '0 &&
                (sched_count % CNT_W'(dim_every)) == '0)
                st.dimming_step = 1'b1;

            // Every whole hour inside a phase takes one off the hours left, down to zero.
            if (sched_count != '0 && (sched_count % SEC_PER_HOUR) == '0 && sched_hours != '0)
                sched_hours = sched_hours - HOURS_W'(1);

            tod_s = tod_s + MIN_W'(1);
            if (tod_s >= SEC_PER_MIN) begin
                tod_s = '0;
                tod_m = tod_m + MIN_W'(1);
            end
            if (tod_m >= MIN_PER_HOUR) begin
                tod_m = '0;
                tod_h = tod_h + HOURS_W'(1);
            end
            if (tod_h >= HOURS_PER_DAY)
                tod_h = '0;

            // A log period of zero requests a log on every tick.
            if (log_count < CNT_MAX)
                log_count = log_count + CNT_W'(1);
            if (log_count >= log_every) begin
                log_count      = '0;
                st.log_request = 1'b1;
            end
        end
        st.phase         = sched_phase;
        st.phase_seconds = sched_count;
        st.hours_left    = sched_hours;
        st.clock_hour    = tod_h;
        st.clock_minute  = tod_m;
        st.clock_second  = tod_s;
        return st;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Holds one request on the input until the block takes it, then records what it
    // should produce. Valid is left high on return so that a back-to-back request
    // never lowers and raises it in the same step; the caller lowers it for a gap.
    task automatic push_request(input logic tick, input logic typed, input status_t known);
        status_t predicted;
        in_valid    <= 1'b1;
        second_tick <= tick;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = advance_schedule(tick);
        status_due.push_back(typed ? known : predicted);
    endtask

    // Writes one register. The write enable stays high on return; the caller lowers it
    // after the last write of a batch.
    task automatic write_register(input logic [CFG_A_W-1:0] addr,
                                  input logic [CFG_D_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        case (addr)
            CFG_DAY_HOURS:        day_len   = value[HOURS_W-1:0];
            CFG_NIGHT_HOURS:      night_len = value[HOURS_W-1:0];
            CFG_TRANSITION_HOURS: dusk_len  = value[HOURS_W-1:0];
            CFG_DIMMING_INTERVAL: dim_every = value[DIV_W-1:0];
            CFG_LOG_PERIOD:       log_every = value[CNT_W-1:0];
            default:              ;
        endcase
    endtask

    // Waits until every owed result has come back and the block has had time to settle.
    task automatic wait_until_idle();
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One random stretch: reprogram all five registers while idle, then send requests
    // in bursts of random length separated by random gaps. Some bursts start with no gap
    // at all, so the input also sees long unbroken runs.
    task automatic run_segment(input int unsigned day_h, input int unsigned night_h,
                               input int unsigned dusk_h, input int unsigned dim,
                               input int unsigned logp, input int unsigned count,
                               input int unsigned tick_pct);
        int unsigned burst;
        int unsigned gap;
        in_valid <= 1'b0;
        wait_until_idle();
        write_register(CFG_DAY_HOURS, CFG_D_W'(day_h));
        write_register(CFG_NIGHT_HOURS, CFG_D_W'(night_h));
        write_register(CFG_TRANSITION_HOURS, CFG_D_W'(dusk_h));
        write_register(CFG_DIMMING_INTERVAL, CFG_D_W'(dim));
        write_register(CFG_LOG_PERIOD, CFG_D_W'(logp));
        cfg_we <= 1'b0;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            push_request($urandom_range(0, 99) < tick_pct, 1'b0, '0);
            burst--;
        end
    endtask

    // Mostly zero hours, now and then one: phases then change on nearly every tick.
    function automatic int unsigned brief_hours();
        return ($urandom_range(0, 3) == 0) ? 1 : 0;
    endfunction

    // Directed rows. The directed part stays inside the first minute of the clock, so
    // the typed expectations leave hour and minute at zero.
    function automatic stim_row_t row_write(input logic [CFG_A_W-1:0] addr,
                                            input logic [CFG_D_W-1:0] data);
        stim_row_t r;
        r       = '{kind: ROW_WRITE, addr: addr, data: data, tick: 1'b0, typed: 1'b0,
                    want: '0};
        return r;
    endfunction

    function automatic stim_row_t row_send(input logic tick);
        stim_row_t r;
        r = '{kind: ROW_SEND, addr: '0, data: '0, tick: tick, typed: 1'b0, want: '0};
        return r;
    endfunction

    // Pulses are given as {dimming_step, refresh_dimming, phase_changed, log_request}.
    function automatic stim_row_t row_known(input logic tick, input logic [1:0] ph,
                                            input logic [CNT_W-1:0] secs,
                                            input logic [HOURS_W-1:0] hrs,
                                            input logic [MIN_W-1:0] clk_sec,
                                            input logic [3:0] pulses);
        stim_row_t r;
        r                       = row_send(tick);
        r.typed                 = 1'b1;
        r.want                  = '0;
        r.want.phase            = ph;
        r.want.phase_seconds    = secs;
        r.want.hours_left       = hrs;
        r.want.clock_second     = clk_sec;
        r.want.dimming_step     = pulses[3];
        r.want.refresh_dimming  = pulses[2];
        r.want.phase_changed    = pulses[1];
        r.want.log_request      = pulses[0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        stim_row_t rows[$];

        // The predictor starts from the reset state: day phase, everything cleared,
        // registers at their defaults.
        day_len     = DAY_HOURS_RST;
        night_len   = NIGHT_HOURS_RST;
        dusk_len    = TRANS_HOURS_RST;
        dim_every   = DIM_INTVL_RST;
        log_every   = LOG_PERIOD_RST;
        sched_phase = PHASE_DAY;
        sched_count = '0;
        sched_hours = '0;
        log_count   = '0;
        tod_h       = '0;
        tod_m       = '0;
        tod_s       = '0;

        // Fresh out of reset a poll shows all zeros; a tick counts one second; a poll
        // after it repeats the state with no pulses.
        rows.push_back(row_known(1'b0, PHASE_DAY, 17'd0, 5'd0, 6'd0, 4'b0000));
        rows.push_back(row_known(1'b1, PHASE_DAY, 17'd1, 5'd0, 6'd1, 4'b0000));
        rows.push_back(row_known(1'b0, PHASE_DAY, 17'd1, 5'd0, 6'd1, 4'b0000));
        // A log period of zero asks for a log on every tick from here on.
        rows.push_back(row_write(CFG_LOG_PERIOD, 17'd0));
        rows.push_back(row_known(1'b1, PHASE_DAY, 17'd2, 5'd0, 6'd2, 4'b0001));
        // Day length cut to zero under a running count: the day ends on the next tick,
        // the dusk transition starts with a dimming step on its cleared count.
        rows.push_back(row_write(CFG_DAY_HOURS, 17'd0));
        rows.push_back(row_known(1'b1, PHASE_TO_NIGHT, 17'd0, 5'd1, 6'd3, 4'b1011));
        rows.push_back(row_known(1'b1, PHASE_TO_NIGHT, 17'd1, 5'd1, 6'd4, 4'b0001));
        // Leaving a transition raises the refresh pulse and loads the night length.
        rows.push_back(row_write(CFG_TRANSITION_HOURS, 17'd0));
        rows.push_back(row_known(1'b1, PHASE_NIGHT, 17'd0, 5'd10, 6'd5, 4'b0111));
        // A dimming interval of zero never steps, even on a cleared count.
        rows.push_back(row_write(CFG_NIGHT_HOURS, 17'd0));
        rows.push_back(row_write(CFG_DIMMING_INTERVAL, 17'd0));
        rows.push_back(row_known(1'b1, PHASE_TO_DAY, 17'd0, 5'd0, 6'd6, 4'b0011));
        rows.push_back(row_known(1'b1, PHASE_DAY, 17'd0, 5'd0, 6'd7, 4'b0111));
        // Every register at the top of its field.
        rows.push_back(row_write(CFG_DAY_HOURS, 17'h1FFFF));
        rows.push_back(row_write(CFG_NIGHT_HOURS, 17'h1FFFF));
        rows.push_back(row_write(CFG_TRANSITION_HOURS, 17'h1FFFF));
        rows.push_back(row_write(CFG_DIMMING_INTERVAL, 17'h1FFFF));
        rows.push_back(row_write(CFG_LOG_PERIOD, 17'h1FFFF));
        rows.push_back(row_known(1'b1, PHASE_DAY, 17'd1, 5'd0, 6'd8, 4'b0000));
        rows.push_back(row_known(1'b0, PHASE_DAY, 17'd1, 5'd0, 6'd8, 4'b0000));
        // Writes to the unused indexes must change nothing.
        rows.push_back(row_write(CFG_LOG_PERIOD + 3'd1, 17'h1FFFF));
        rows.push_back(row_write(CFG_LOG_PERIOD + 3'd2, 17'd0));
        rows.push_back(row_write(CFG_LOG_PERIOD + 3'd3, 17'h1FFFF));
        rows.push_back(row_write(CFG_DAY_HOURS, 17'd0));
        rows.push_back(row_known(1'b1, PHASE_TO_NIGHT, 17'd0, 5'd31, 6'd9, 4'b1010));
        // Interval of one steps on every tick; log period of one logs on the next tick.
        rows.push_back(row_write(CFG_DIMMING_INTERVAL, 17'd1));
        rows.push_back(row_known(1'b1, PHASE_TO_NIGHT, 17'd1, 5'd31, 6'd10, 4'b1000));
        rows.push_back(row_write(CFG_LOG_PERIOD, 17'd1));
        rows.push_back(row_known(1'b1, PHASE_TO_NIGHT, 17'd2, 5'd31, 6'd11, 4'b1001));
        // The rest of the table is left to the predictor.
        rows.push_back(row_write(CFG_DIMMING_INTERVAL, 17'd3));
        rows.push_back(row_send(1'b1));
        rows.push_back(row_send(1'b1));
        rows.push_back(row_send(1'b0));
        rows.push_back(row_write(CFG_TRANSITION_HOURS, 17'd0));
        rows.push_back(row_send(1'b1));
        rows.push_back(row_send(1'b1));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the table. Registers are only written with nothing in flight.
        foreach (rows[i]) begin
            if (rows[i].kind == ROW_WRITE) begin
                in_valid <= 1'b0;
                wait_until_idle();
                write_register(rows[i].addr, rows[i].data);
                cfg_we <= 1'b0;
            end else begin
                push_request(rows[i].tick, rows[i].typed, rows[i].want);
            end
        end

        // Very short phases: changes, refreshes and dimming steps on almost every tick.
        for (int seg = 0; seg < 4; seg++)
            run_segment(brief_hours(), brief_hours(), brief_hours(),
                        $urandom_range(0, 4), $urandom_range(0, 6), 40, 75);

        // Long stay in a transition with a small interval: a steady train of steps.
        run_segment(0, 0, 1, $urandom_range(1, 7), $urandom_range(1, 50), 120, 85);

        // Lowest and highest legal settings.
        run_segment(1, 1, 1, 1, 1, 30, 80);
        run_segment(24, 24, 24, 65535, 86400, 30, 60);

        // A steady stretch in a two-hour day: the count climbs with no phase change.
        run_segment(2, 2, 0, $urandom_range(1, 9), $urandom_range(1, 1000), 80, 98);

        for (int seg = 0; seg < 2; seg++)
            run_segment(brief_hours(), brief_hours(), brief_hours(),
                        $urandom_range(0, 65535), $urandom_range(0, 131071), 40, 70);

        // Back to the defaults.
        run_segment(DAY_HOURS_RST, NIGHT_HOURS_RST, TRANS_HOURS_RST, DIM_INTVL_RST,
                    LOG_PERIOD_RST, 40, 70);

        in_valid <= 1'b0;
        wait_until_idle();

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: back-pressure and checking
    // ------------------------------------------------------------------

    // The ready pattern switches at random among four modes: always open, random, open in a
    // sparse periodic pattern, or held off in periodic runs.
    always @(posedge clk) begin
        if (sink_left == 0) begin
            sink_mode = sink_mode_e'($urandom_range(0, 3));
            sink_left = $urandom_range(20, 150);
        end
        sink_left = sink_left - 1;
        sink_beat = sink_beat + 1;
        case (sink_mode)
            SINK_OPEN:    out_ready <= 1'b1;
            SINK_RANDOM:  out_ready <= 1'($urandom_range(0, 1));
            SINK_QUARTER: out_ready <= (sink_beat % 4) == 0;
            default:      out_ready <= (sink_beat % 8) >= 5;
        endcase
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Every accepted result is matched against the oldest outstanding expectation.
    always @(posedge clk) begin : result_check
        status_t want;
        if (rst_n && out_valid && out_ready) begin
            if (status_due.size() == 0) begin
                $error("result accepted with no request outstanding");
                mismatches++;
            end else begin
                want = status_due.pop_front();
                check_field("phase", 32'(want.phase), 32'(phase));
                check_field("phase_seconds", 32'(want.phase_seconds), 32'(phase_seconds));
                check_field("hours_left", 32'(want.hours_left), 32'(hours_left));
                check_field("clock_hour", 32'(want.clock_hour), 32'(clock_hour));
                check_field("clock_minute", 32'(want.clock_minute), 32'(clock_minute));
                check_field("clock_second", 32'(want.clock_second), 32'(clock_second));
                check_field("dimming_step", 32'(want.dimming_step), 32'(dimming_step));
                check_field("refresh_dimming", 32'(want.refresh_dimming),
                            32'(refresh_dimming));
                check_field("phase_changed", 32'(want.phase_changed), 32'(phase_changed));
                check_field("log_request", 32'(want.log_request), 32'(log_request));
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $error("timeout after %0d cycles, %0d results outstanding",
                   cycles, status_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule

### files.f
rtl/pps_pkg.sv
rtl/pps_serial_mod.sv
rtl/photoperiod_phase_sequencer.sv
test/tb_photoperiod_phase_sequencer.sv
